// File: sv/sca_pkg.sv
// sca_pkg: shared widths, switch indexes and record types for the stripe counter
// used by sca_step, stripe_counter_autocal_unit and sca_checker
`default_nettype none

package sca_pkg;

    // field widths
    localparam int SENSOR_BITS  = 10;
    localparam int SWITCH_COUNT = 6;
    localparam int SUM_W        = SENSOR_BITS + 1;
    localparam int MIN_W        = SENSOR_BITS + 2;
    localparam int THR_W        = SENSOR_BITS + 3;
    localparam int CNT_W        = 8;

    // calibration marks
    localparam logic [MIN_W-1:0] MIN_NONE = {MIN_W{1'b1}};
    localparam logic [SUM_W-1:0] MAX_NONE = '0;

    // switch roles
    localparam int SW_CLEAR  = 0;
    localparam int SW_RECAL  = 1;
    localparam int SW_REPORT = 2;

    // running state carried from item to item
    typedef struct packed {
        logic [SWITCH_COUNT-1:0] prev_sw;
        logic [MIN_W-1:0]        min_sum;
        logic [SUM_W-1:0]        max_sum;
        logic                    white;
        logic [CNT_W-1:0]        stripe_cnt;
        logic [CNT_W-1:0]        change_cnt;
        logic                    report;
    } state_t;

    // one result item
    typedef struct packed {
        logic [SUM_W-1:0] line_sum;
        logic [MIN_W-1:0] low_mark;
        logic [SUM_W-1:0] high_mark;
        logic             on_white;
        logic [CNT_W-1:0] stripe_total;
        logic [CNT_W-1:0] change_total;
        logic             counts_event;
        logic             report_levels;
    } result_t;

endpackage

`default_nettype wire

// File: sv/sca_step.sv
// sca_step: combinational step of the stripe counter, switches, calibration, class
// depends on sca_pkg for widths, state_t and result_t
`default_nettype none

module sca_step (
    input  sca_pkg::state_t                     cur,
    input  logic [sca_pkg::SENSOR_BITS-1:0]     sensor_left,
    input  logic [sca_pkg::SENSOR_BITS-1:0]     sensor_right,
    input  logic [sca_pkg::SWITCH_COUNT-1:0]    switch_bits,
    output sca_pkg::state_t                     nxt,
    output sca_pkg::result_t                    res
);
    import sca_pkg::*;

    logic [SWITCH_COUNT-1:0] rise;
    logic [SUM_W-1:0]        sum;
    logic [MIN_W-1:0]        min_sw;
    logic [SUM_W-1:0]        max_sw;
    logic [MIN_W-1:0]        min_cal;
    logic [SUM_W-1:0]        max_cal;
    logic [THR_W-1:0]        black_thr;
    logic [THR_W-1:0]        max_x3;
    logic [SUM_W-1:0]        white_thr;
    logic                    white_base;
    logic                    white_new;
    logic [CNT_W-1:0]        stripe_base;
    logic [CNT_W-1:0]        change_base;
    logic                    changed;

    // rising switch edges and the sensor sum
    assign rise = switch_bits & ~cur.prev_sw;
    assign sum  = SUM_W'({1'b0, sensor_left}) + SUM_W'({1'b0, sensor_right});

    // switch actions
    assign stripe_base = rise[SW_CLEAR] ? '0 : cur.stripe_cnt;
    assign change_base = rise[SW_CLEAR] ? '0 : cur.change_cnt;
    assign white_base  = rise[SW_CLEAR] ? 1'b1 : cur.white;
    assign min_sw      = rise[SW_RECAL] ? MIN_NONE : cur.min_sum;
    assign max_sw      = rise[SW_RECAL] ? MAX_NONE : cur.max_sum;

    // widen the calibration range
    always_comb
    begin
        min_cal = min_sw;
        max_cal = max_sw;
        if (MIN_W'(sum) < min_sw)
        begin
            min_cal = MIN_W'(sum);
        end
        else if (sum > max_sw)
        begin
            max_cal = sum;
        end
    end

    // thresholds at 1.25 * min and 0.75 * max
    assign black_thr = THR_W'(min_cal) + THR_W'(min_cal >> 2);
    assign max_x3    = THR_W'({max_cal, 1'b0}) + THR_W'(max_cal);
    assign white_thr = SUM_W'(max_x3 >> 2);

    // classify with hysteresis
    always_comb
    begin
        priority if (THR_W'(sum) < black_thr)
        begin
            white_new = 1'b0;
        end
        else if (sum > white_thr)
        begin
            white_new = 1'b1;
        end
        else
        begin
            white_new = white_base;
        end
    end

    assign changed = (white_new != white_base);

    // next state
    always_comb
    begin
        nxt.prev_sw    = switch_bits;
        nxt.min_sum    = min_cal;
        nxt.max_sum    = max_cal;
        nxt.white      = white_new;
        nxt.stripe_cnt = (changed && !white_new) ? stripe_base + CNT_W'(1) : stripe_base;
        nxt.change_cnt = changed ? change_base + CNT_W'(1) : change_base;
        nxt.report     = rise[SW_REPORT] ? ~cur.report : cur.report;
    end

    // result item
    always_comb
    begin
        res.line_sum      = sum;
        res.low_mark      = nxt.min_sum;
        res.high_mark     = nxt.max_sum;
        res.on_white      = nxt.white;
        res.stripe_total  = nxt.stripe_cnt;
        res.change_total  = nxt.change_cnt;
        res.counts_event  = rise[SW_CLEAR] | changed;
        res.report_levels = nxt.report;
    end

endmodule

`default_nettype wire

// File: sv/stripe_counter_autocal_unit.sv
// stripe_counter_autocal_unit: an input transfer reaches result valid through the registers below
// throughput one item per cycle while out_stall does not hold a full result register, set by the state update loop
// input register, then the combinational step, then the result register
// a full result register holds under out_stall while an empty input register still fills
// rst_n async low: pipeline empty, min 4095, max 0, white, counters 0, report on
`default_nettype none

module stripe_counter_autocal_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sca_pkg::SENSOR_BITS-1:0]     sensor_left,
    input  logic [sca_pkg::SENSOR_BITS-1:0]     sensor_right,
    input  logic [sca_pkg::SWITCH_COUNT-1:0]    switch_bits,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sca_pkg::SUM_W-1:0]           line_sum,
    output logic [sca_pkg::MIN_W-1:0]           low_mark,
    output logic [sca_pkg::SUM_W-1:0]           high_mark,
    output logic                                on_white,
    output logic [sca_pkg::CNT_W-1:0]           stripe_total,
    output logic [sca_pkg::CNT_W-1:0]           change_total,
    output logic                                counts_event,
    output logic                                report_levels
);
    import sca_pkg::*;

    logic                    in_valid_reg;
    logic [SENSOR_BITS-1:0]  left_reg;
    logic [SENSOR_BITS-1:0]  right_reg;
    logic [SWITCH_COUNT-1:0] sw_reg;
    state_t                  state_reg;
    state_t                  state_next;
    result_t                 res_next;
    result_t                 res_reg;
    logic                    out_valid_reg;
    logic                    out_busy;
    logic                    advance;

    // handshake control
    assign out_busy = out_valid_reg & out_stall;
    assign in_stall = in_valid_reg & out_busy;
    assign advance  = in_valid_reg & ~out_busy;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            left_reg  <= sensor_left;
            right_reg <= sensor_right;
            sw_reg    <= switch_bits;
        end
    end

    // step logic
    sca_step u_step (
        .cur          (state_reg),
        .sensor_left  (left_reg),
        .sensor_right (right_reg),
        .switch_bits  (sw_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    // running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_sw    <= '0;
            state_reg.min_sum    <= MIN_NONE;
            state_reg.max_sum    <= MAX_NONE;
            state_reg.white      <= 1'b1;
            state_reg.stripe_cnt <= '0;
            state_reg.change_cnt <= '0;
            state_reg.report     <= 1'b1;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_busy)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign line_sum      = res_reg.line_sum;
    assign low_mark      = res_reg.low_mark;
    assign high_mark     = res_reg.high_mark;
    assign on_white      = res_reg.on_white;
    assign stripe_total  = res_reg.stripe_total;
    assign change_total  = res_reg.change_total;
    assign counts_event  = res_reg.counts_event;
    assign report_levels = res_reg.report_levels;

endmodule

`default_nettype wire

// File: sv/sca_checker.sv
// sca_checker: port-level checks on the stripe counter results over time
// depends on sca_pkg widths; bound to stripe_counter_autocal_unit below
`default_nettype none

module sca_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [sca_pkg::SUM_W-1:0]           line_sum,
    input  logic [sca_pkg::MIN_W-1:0]           low_mark,
    input  logic [sca_pkg::CNT_W-1:0]           stripe_total,
    input  logic [sca_pkg::CNT_W-1:0]           change_total,
    input  logic                                counts_event
);
    import sca_pkg::*;

    logic out_xfer;

    assign out_xfer = out_valid & ~out_stall;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_sum) && $stable(stripe_total))
        else $error("stalled result changed");

    // the minimum never sits above the sum it has just seen
    a_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> MIN_W'(line_sum) >= low_mark)
        else $error("low mark above line sum");

    // no event on back-to-back transfers means counters untouched
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && $past(out_xfer) && !counts_event |->
            stripe_total == $past(stripe_total) && change_total == $past(change_total))
        else $error("counters moved without event");

    // stripe count only stays, steps by one or clears to 0 or 1 between back-to-back transfers
    a_stripe: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && $past(out_xfer) |->
            stripe_total == $past(stripe_total) ||
            stripe_total == CNT_W'($past(stripe_total) + CNT_W'(1)) ||
            stripe_total == '0 || stripe_total == CNT_W'(1))
        else $error("stripe count jumped");

endmodule

bind stripe_counter_autocal_unit sca_checker u_sca_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_sum     (line_sum),
    .low_mark     (low_mark),
    .stripe_total (stripe_total),
    .change_total (change_total),
    .counts_event (counts_event)
);

`default_nettype wire
